FILE: rtl/core/wsd_pkg.sv
// Package with the widths, request codes and word types of the work-stealing deque.
package wsd_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int PTR_W    = SLOT_W + 1;
    localparam int TASK_W   = 32;
    localparam int COUNT_W  = PTR_W;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_STEAL = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type           req_type;
        logic [TASK_W-1:0]   task_handle;
    } t_req_word;

    typedef struct packed {
        logic                ok;
        logic [TASK_W-1:0]   task_out;
        logic [COUNT_W-1:0]  task_count;
    } t_rsp_word;

endpackage

FILE: rtl/core/work_stealing_deque.sv
// Top level of the work-stealing deque: request register, ring of slots and response register.
//
// A ring of CAPACITY task slots with a bottom end for push and pop and a top end for steal.
// Every request word gives exactly one response word, which passes the request register and then
// the response register; the latter loads when it is empty or the response side is ready. One
// request is taken every cycle while the response side keeps up: the slot is read as the request
// is registered, the pointer compare and the pointer update fit between the request register and
// the response register, and the request register holds one more request while a response waits.
module work_stealing_deque (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  wsd_pkg::t_req_word i_req_word,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output wsd_pkg::t_rsp_word o_rsp_word
);
    import wsd_pkg::*;

    logic                r_in_valid;
    t_req_word           r_in;
    logic                r_out_valid;
    t_rsp_word           r_out;
    logic [PTR_W-1:0]    r_top;
    logic [PTR_W-1:0]    r_bot;
    logic [TASK_W-1:0]   r_slot [CAPACITY];
    logic [TASK_W-1:0]   r_rd_data;

    logic                w_adv;
    logic [PTR_W-1:0]    w_count;
    logic                w_full;
    logic                w_empty;
    logic [PTR_W-1:0]    w_last;
    logic [PTR_W-1:0]    w_nx_top;
    logic [PTR_W-1:0]    w_nx_bot;
    logic [PTR_W-1:0]    w_nx_last;
    logic [SLOT_W-1:0]   w_rd_addr;
    logic                w_fwd;
    logic                w_wr_en;
    logic [PTR_W-1:0]    n_top;
    logic [PTR_W-1:0]    n_bot;
    t_rsp_word           n_out;

    assign w_adv       = r_in_valid && (!r_out_valid || i_rsp_ready);
    assign o_req_ready = !r_in_valid || w_adv;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp_word  = r_out;

    assign w_count   = r_bot - r_top;
    assign w_full    = (w_count == PTR_W'(CAPACITY));
    assign w_empty   = (w_count == '0);
    assign w_last    = r_bot - PTR_W'(1);

    // The incoming word sees the pointers as they stand after the word ahead of it.
    assign w_nx_top  = w_adv ? n_top : r_top;
    assign w_nx_bot  = w_adv ? n_bot : r_bot;
    assign w_nx_last = w_nx_bot - PTR_W'(1);
    assign w_rd_addr = (i_req_word.req_type == REQ_POP) ? w_nx_last[SLOT_W-1:0]
                                                        : w_nx_top[SLOT_W-1:0];
    assign w_fwd     = w_adv && w_wr_en && (w_rd_addr == r_bot[SLOT_W-1:0]);

    always_comb begin
        n_top          = r_top;
        n_bot          = r_bot;
        w_wr_en        = 1'b0;
        n_out.ok       = 1'b0;
        n_out.task_out = '0;
        unique case (r_in.req_type)
            REQ_PUSH: begin
                if (!w_full) begin
                    w_wr_en  = 1'b1;
                    n_bot    = r_bot + PTR_W'(1);
                    n_out.ok = 1'b1;
                end
            end
            REQ_POP: begin
                if (!w_empty) begin
                    n_out.ok       = 1'b1;
                    n_out.task_out = r_rd_data;
                    if (w_count == PTR_W'(1)) begin
                        n_top = r_top + PTR_W'(1);
                    end else begin
                        n_bot = w_last;
                    end
                end
            end
            REQ_STEAL: begin
                if (!w_empty) begin
                    n_out.ok       = 1'b1;
                    n_out.task_out = r_rd_data;
                    n_top          = r_top + PTR_W'(1);
                end
            end
            default: begin
            end
        endcase
        n_out.task_count = COUNT_W'(n_bot - n_top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_top       <= '0;
            r_bot       <= '0;
        end else begin
            if (o_req_ready) begin
                r_in_valid <= i_req_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_top       <= n_top;
                r_bot       <= n_bot;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_in <= i_req_word;
            if (w_fwd) begin
                r_rd_data <= r_in.task_handle;
            end else begin
                r_rd_data <= r_slot[w_rd_addr];
            end
        end
        if (w_adv) begin
            r_out <= n_out;
        end
        if (w_adv && w_wr_en) begin
            r_slot[r_bot[SLOT_W-1:0]] <= r_in.task_handle;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bot - r_top) <= PTR_W'(CAPACITY))
        else $error("Task count exceeds the ring capacity.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp_word.ok) |-> (o_rsp_word.task_out == '0))
        else $error("Failed request returned a nonzero task.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_top) && $stable(r_bot)))
        else $error("Pointers moved without a request being processed.");

endmodule

FILE: bench/work_stealing_deque_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the work-stealing deque: directed table, then random traffic.
module work_stealing_deque_test;
    import wsd_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int PHASE_ITEMS  = 363;
    localparam int BURST_ITEMS  = 24;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        t_req_word   word;
        int unsigned reps;
        bit          typed;
        t_rsp_word   rsp;
    } t_table_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      req_valid;
    logic      o_req_ready;
    t_req_word req_word;
    logic      o_rsp_valid;
    logic      rsp_ready;
    t_rsp_word rsp_word;

    logic [TASK_W-1:0] ring [CAPACITY];
    logic [PTR_W-1:0]  top_ptr = '0;
    logic [PTR_W-1:0]  bot_ptr = '0;
    t_rsp_word         pending_rsp [$];
    t_table_row        steps [$];
    int unsigned       send_idle_pct = 0;
    int unsigned       rsp_stall_pct = 0;
    int unsigned       mismatches = 0;
    int unsigned       cycles = 0;

    work_stealing_deque dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (o_req_ready),
        .i_req_word  (req_word),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp_word  (rsp_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Applies one request word to the local copy of the ring and returns the expected response.
    function automatic t_rsp_word deque_apply(input t_req_word word);
        t_rsp_word        rsp;
        logic [PTR_W-1:0] held;
        logic [PTR_W-1:0] last;
        held = bot_ptr - top_ptr;
        rsp  = '0;
        case (word.req_type)
            REQ_PUSH: begin
                if (held < PTR_W'(CAPACITY)) begin
                    ring[bot_ptr[SLOT_W-1:0]] = word.task_handle;
                    bot_ptr = bot_ptr + PTR_W'(1);
                    rsp.ok = 1'b1;
                end
            end
            REQ_POP: begin
                if (held != '0) begin
                    last = bot_ptr - PTR_W'(1);
                    rsp.task_out = ring[last[SLOT_W-1:0]];
                    if (held == PTR_W'(1)) begin
                        top_ptr = top_ptr + PTR_W'(1);
                    end else begin
                        bot_ptr = last;
                    end
                    rsp.ok = 1'b1;
                end
            end
            REQ_STEAL: begin
                if (held != '0) begin
                    rsp.task_out = ring[top_ptr[SLOT_W-1:0]];
                    top_ptr = top_ptr + PTR_W'(1);
                    rsp.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        rsp.task_count = COUNT_W'(bot_ptr - top_ptr);
        return rsp;
    endfunction

    function automatic void add_row(input t_req_type kind, input logic [TASK_W-1:0] handle,
                                    input int unsigned reps, input bit typed, input logic ok,
                                    input logic [TASK_W-1:0] taken,
                                    input logic [COUNT_W-1:0] held);
        t_table_row row;
        row.word.req_type    = kind;
        row.word.task_handle = handle;
        row.reps             = reps;
        row.typed            = typed;
        row.rsp.ok           = ok;
        row.rsp.task_out     = taken;
        row.rsp.task_count   = held;
        steps.push_back(row);
    endfunction

    // Presents one request word after a random gap and records its expected response.
    task automatic issue_request(input t_req_word word, input bit typed,
                                 input t_rsp_word typed_rsp);
        t_rsp_word predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge i_clk);
        end
        req_valid <= 1'b1;
        req_word  <= word;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        predicted = deque_apply(word);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
    endtask

    initial begin
        rsp_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_rsp_word want;
        if (i_rst_n && o_rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected response word: ok=%0d task=%h count=%0d",
                             rsp_word.ok, rsp_word.task_out, rsp_word.task_count);
                end
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_word.ok !== want.ok || rsp_word.task_out !== want.task_out
                        || rsp_word.task_count !== want.task_count) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("mismatch: expected ok=%0d task=%h count=%0d, got ok=%0d task=%h count=%0d",
                                 want.ok, want.task_out, want.task_count,
                                 rsp_word.ok, rsp_word.task_out, rsp_word.task_count);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        t_req_word   word;
        int unsigned push_pct;
        int unsigned pick;
        i_rst_n   = 1'b0;
        req_valid = 1'b0;
        req_word  = '0;
        push_pct  = 50;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(REQ_POP,   32'h0000_0000,  1, 1'b1, 1'b0, 32'h0000_0000, 5'd0);
        add_row(REQ_STEAL, 32'h0000_0000,  1, 1'b1, 1'b0, 32'h0000_0000, 5'd0);
        add_row(REQ_NONE,  32'hFFFF_FFFF,  1, 1'b1, 1'b0, 32'h0000_0000, 5'd0);
        add_row(REQ_PUSH,  32'hFFFF_FFFF,  1, 1'b1, 1'b1, 32'h0000_0000, 5'd1);
        add_row(REQ_POP,   32'h0000_0000,  1, 1'b1, 1'b1, 32'hFFFF_FFFF, 5'd0);
        add_row(REQ_PUSH,  32'h0000_0000,  1, 1'b1, 1'b1, 32'h0000_0000, 5'd1);
        add_row(REQ_STEAL, 32'hFFFF_FFFF,  1, 1'b1, 1'b1, 32'h0000_0000, 5'd0);
        add_row(REQ_PUSH,  32'h8000_0000, 16, 1'b0, 1'b0, 32'h0000_0000, 5'd0);
        add_row(REQ_PUSH,  32'h1234_5678,  1, 1'b1, 1'b0, 32'h0000_0000, 5'd16);
        add_row(REQ_STEAL, 32'h0000_0000,  1, 1'b0, 1'b0, 32'h0000_0000, 5'd0);
        add_row(REQ_PUSH,  32'h7FFF_FFFF,  1, 1'b0, 1'b0, 32'h0000_0000, 5'd0);
        add_row(REQ_POP,   32'h0000_0000,  1, 1'b0, 1'b0, 32'h0000_0000, 5'd0);

        for (int r = 0; r < steps.size(); r++) begin
            for (int unsigned i = 0; i < steps[r].reps; i++) begin
                word = steps[r].word;
                word.task_handle = word.task_handle + TASK_W'(i);
                issue_request(word, steps[r].typed, steps[r].rsp);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 79;
                    rsp_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 79;
                end
                default: begin
                    send_idle_pct = 6;
                    rsp_stall_pct = 6;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % BURST_ITEMS == 0) begin
                    case ($urandom_range(2))
                        0: push_pct = 15;
                        1: push_pct = 50;
                        default: push_pct = 85;
                    endcase
                end
                pick = $urandom_range(99);
                if (pick < 3) begin
                    word.req_type = REQ_NONE;
                end else if (pick < 3 + push_pct) begin
                    word.req_type = REQ_PUSH;
                end else if ($urandom_range(1) == 0) begin
                    word.req_type = REQ_POP;
                end else begin
                    word.req_type = REQ_STEAL;
                end
                case ($urandom_range(9))
                    0: word.task_handle = '0;
                    1: word.task_handle = '1;
                    default: word.task_handle = TASK_W'($urandom);
                endcase
                issue_request(word, 1'b0, '0);
            end
        end

        @(negedge i_clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
